>>> rtl/modbus_response_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Modbus response receiver assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RESPONSE_RECEIVER_UNIT_ASSERT_SVH
`define MODBUS_RESPONSE_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define MBRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbrr assertion failed");

// next-cycle implication
`define MBRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbrr assertion failed");

`endif

>>> rtl/mbrr_pkg.sv
// ----------------------------------------------------------------------------
// mbrr_pkg
// Types and constants shared by the Modbus response receiver modules.
// ----------------------------------------------------------------------------
package mbrr_pkg;

  localparam int MAX_FRAME_DEF = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [4:0]  FRAME_LEN_MIN   = 5'd5;
  localparam logic [4:0]  FRAME_LEN_RESET = 5'd7;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 1'd1;

  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  frame_length;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  byte_total;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] data_word;
  } result_t;

endpackage

>>> rtl/mbrr_crc_byte.sv
// ----------------------------------------------------------------------------
// mbrr_crc_byte
// Folds one byte into a reflected CRC-16, LSB first.
// ----------------------------------------------------------------------------
module mbrr_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mbrr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> rtl/mbrr_frame_core.sv
// ----------------------------------------------------------------------------
// mbrr_frame_core
// Frame state (byte count, CRC, tick count, captured bytes) and result register.
// ----------------------------------------------------------------------------
module mbrr_frame_core #(
  parameter int MAX_FRAME = mbrr_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mbrr_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  mbrr_pkg::item_t   item,
  output logic              fire,
  output logic              res_valid,
  output mbrr_pkg::result_t res,
  input  logic              res_ready
);

  `include "modbus_response_receiver_unit_assert.svh"

  // frame_length is 5 bits wide, so the cap never exceeds 31
  localparam int LenCapInt = (MAX_FRAME > 31) ? 31 : MAX_FRAME;
  localparam logic [4:0] LenCap = 5'(LenCapInt);

  logic        armed_r, armed_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] data_r, data_nxt;

  logic              res_valid_r;
  mbrr_pkg::result_t res_r, res_nxt;
  logic              emit;

  logic [4:0]  eff_len;
  logic [15:0] crc_fold;

  assign fire = item_valid && (!res_valid_r || res_ready);

  always_comb begin
    priority if (cfg.frame_length < mbrr_pkg::FRAME_LEN_MIN) begin
      eff_len = mbrr_pkg::FRAME_LEN_MIN;
    end else if (cfg.frame_length > LenCap) begin
      eff_len = LenCap;
    end else begin
      eff_len = cfg.frame_length;
    end
  end

  mbrr_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (item.rx_byte),
    .crc_out (crc_fold)
  );

  always_comb begin
    armed_nxt   = armed_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    last_nxt    = last_r;
    addr_nxt    = addr_r;
    func_nxt    = func_r;
    data_nxt    = data_r;
    emit        = 1'b0;
    res_nxt     = res_r;
    if (fire) begin
      unique case (item.mode)
        mbrr_pkg::MODE_START: begin
          armed_nxt   = 1'b1;
          crc_nxt     = mbrr_pkg::CRC_INIT;
          count_nxt   = '0;
          elapsed_nxt = '0;
          last_nxt    = '0;
          addr_nxt    = '0;
          func_nxt    = '0;
          data_nxt    = '0;
        end
        mbrr_pkg::MODE_BYTE: begin
          if (armed_r) begin
            unique case (count_r)
              5'd0:    addr_nxt = item.rx_byte;
              5'd1:    func_nxt = item.rx_byte;
              5'd3:    data_nxt = {item.rx_byte, data_r[7:0]};
              5'd4:    data_nxt = {data_r[15:8], item.rx_byte};
              default: ;
            endcase
            if (count_r < eff_len - 5'd2) begin
              crc_nxt = crc_fold;
            end
            last_nxt  = item.rx_byte;
            count_nxt = count_r + 5'd1;
            if (count_nxt >= eff_len) begin
              emit           = 1'b1;
              armed_nxt      = 1'b0;
              // received CRC: low byte came first, high byte is this item
              res_nxt.status = ({item.rx_byte, last_r} == crc_nxt) ?
                               mbrr_pkg::ST_OK : mbrr_pkg::ST_CRC_ERR;
            end
          end
        end
        mbrr_pkg::MODE_TICK: begin
          if (armed_r) begin
            if (elapsed_r != mbrr_pkg::TICKS_MAX) begin
              elapsed_nxt = elapsed_r + 16'd1;
            end
            if (elapsed_nxt >= cfg.timeout_ms) begin
              emit           = 1'b1;
              armed_nxt      = 1'b0;
              res_nxt.status = mbrr_pkg::ST_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
      if (emit) begin
        res_nxt.byte_total    = count_nxt;
        res_nxt.slave_address = addr_nxt;
        res_nxt.function_code = func_nxt;
        res_nxt.data_word     = data_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      crc_r       <= mbrr_pkg::CRC_INIT;
      count_r     <= '0;
      elapsed_r   <= '0;
      last_r      <= '0;
      addr_r      <= '0;
      func_r      <= '0;
      data_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      armed_r   <= armed_nxt;
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
      last_r    <= last_nxt;
      addr_r    <= addr_nxt;
      func_r    <= func_nxt;
      data_r    <= data_nxt;
      if (emit) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `MBRR_ASSERT_NEXT(a_done_disarms, clk, rst_n, emit, !armed_r)
  `MBRR_ASSERT_NEXT(a_start_clears, clk, rst_n, fire && item.mode == mbrr_pkg::MODE_START,
                    armed_r && count_r == 5'd0 && crc_r == mbrr_pkg::CRC_INIT)
  `MBRR_ASSERT_NOW(a_emit_needs_armed, clk, rst_n, emit, armed_r && fire)
  `MBRR_ASSERT_NOW(a_status_code, clk, rst_n, res_valid_r,
                   res_r.status == mbrr_pkg::ST_OK || res_r.status == mbrr_pkg::ST_CRC_ERR ||
                   res_r.status == mbrr_pkg::ST_TIMEOUT)

endmodule

>>> rtl/modbus_response_receiver_unit.sv
// ----------------------------------------------------------------------------
// modbus_response_receiver_unit
// Modbus RTU response receiver: frame capture, CRC-16 check and timeout.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: mode; tdata: rx_byte
//  out_    | out | out_tvalid/out_tready| tuser: status; tdata: byte_total,
//          |     |                      |   slave_address, function_code,
//          |     |                      |   data_word
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle sustained while the result is not stalled: each item is
//  held in the input register, then the frame core updates state and the result register.
//  out_tvalid rises in the cycle after the core consumes the item that ends a frame.
//  Reset: idle, byte count 0, CRC 0xFFFF, frame_length 7, timeout_ms 100.
//  A stalled result blocks the core only while it is held; the input
//  register then holds one item and in_tready drops.
//  cfg_ready is always high; writes are expected only while idle.
//
module modbus_response_receiver_unit #(
  parameter int MAX_FRAME = mbrr_pkg::MAX_FRAME_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [1:0]                      in_tuser,   // [1:0] mode
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] byte_total, [12:5] slave_address, [20:13] function_code,
  // [36:21] data_word, [39:37] zero
  output logic [mbrr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser,  // [1:0] status
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);

  mbrr_pkg::cfg_t    cfg_r;
  logic              in_valid_r;
  mbrr_pkg::item_t   in_item_r;
  logic              fire;
  logic              res_valid;
  mbrr_pkg::result_t res;

  // config registers; frame_length keeps the low five bits
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length <= mbrr_pkg::FRAME_LEN_RESET;
      cfg_r.timeout_ms   <= mbrr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbrr_pkg::REG_FRAME_LENGTH: cfg_r.frame_length <= cfg_data[4:0];
        mbrr_pkg::REG_TIMEOUT_MS:   cfg_r.timeout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: refills in the same cycle the core consumes it
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.mode    <= in_tuser;
      in_item_r.rx_byte <= in_tdata;
    end
  end

  mbrr_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .fire       (fire),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.status;
  assign out_tdata  = {3'b000, res.data_word, res.function_code,
                       res.slave_address, res.byte_total};

endmodule
